@@ src/lpm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_pkg: shared types and constants of the line position motor mixer
// Sequencer states, action codes, register indexes, reset values and the
// sensor pattern decode table.
// ----------------------------------------------------------------------------
package lpm_pkg;

    localparam int DUTY_MAX_DEF = 1023;

    localparam int GAIN_W = 24;
    localparam int OFS_W  = 10;
    localparam int DUTY_W = 10;
    localparam int POS_W  = 4;
    localparam int PAT_W  = 6;
    localparam int ISUM_W = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [ISUM_W:0] ISUM_LIM = 17'sd32767;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_OFFSET  = 3'd5;

    localparam logic [GAIN_W-1:0] RST_PROP_GAIN    = 24'd2667315;
    localparam logic [GAIN_W-1:0] RST_INTEG_GAIN   = 24'd0;
    localparam logic [GAIN_W-1:0] RST_DERIV_GAIN   = 24'd6796;
    localparam logic [GAIN_W-1:0] RST_MIX_GAIN     = 24'd98304;
    localparam logic [OFS_W-1:0]  RST_RIGHT_OFFSET = 10'd705;
    localparam logic [OFS_W-1:0]  RST_LEFT_OFFSET  = 10'd665;

    typedef enum logic [1:0] {
        ACT_DRIVE = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_HOLD  = 2'd2
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_I,
        ST_MUL_D,
        ST_MUL_P,
        ST_ACC,
        ST_ABS,
        ST_MIX_LO,
        ST_MIX_HI,
        ST_MIX_ACC,
        ST_DUTY,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                    hit;
        logic signed [POS_W-1:0] pos;
    } t_decode;

    // One sensor or two adjacent sensors give a position; bit0 is rightmost.
    function automatic t_decode decode_pattern(input logic [PAT_W-1:0] pat);
        t_decode d;
        d.hit = 1'b1;
        d.pos = 4'sd0;
        case (pat)
            6'h01: d.pos = 4'sd5;
            6'h03: d.pos = 4'sd4;
            6'h02: d.pos = 4'sd3;
            6'h06: d.pos = 4'sd2;
            6'h04: d.pos = 4'sd1;
            6'h0C: d.pos = 4'sd0;
            6'h08: d.pos = -4'sd1;
            6'h18: d.pos = -4'sd2;
            6'h10: d.pos = -4'sd3;
            6'h30: d.pos = -4'sd4;
            6'h20: d.pos = -4'sd5;
            default: d.hit = 1'b0;
        endcase
        return d;
    endfunction

    // Clamp a signed duty sum to 0..dmax and keep the output field's bits.
    function automatic logic [DUTY_W-1:0] sat_duty(input logic signed [33:0] v,
                                                   input logic signed [33:0] dmax);
        logic signed [33:0] r;
        if (v < 34'sd0) begin
            r = 34'sd0;
        end else if (v > dmax) begin
            r = dmax;
        end else begin
            r = v;
        end
        return r[DUTY_W-1:0];
    endfunction

endpackage

@@ src/line_position_pd_motor_mixer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_position_pd_motor_mixer: line sensor PID control with motor mixing
// Decodes a six-sensor sample to a line position, runs one PID step and
// mixes the result into saturated left and right motor duties.
// ----------------------------------------------------------------------------
// Each item is one six-bit line sensor sample (bit0 the rightmost sensor) and
// gives one result item: left and right duties, an action code (drive, stop,
// hold) and the decoded line position. A sample with no line seen stops both
// motors at DUTY_MAX unless the last position is at an edge (+-5), where the
// last duties are held. On that path the sequencer goes from ST_IDLE to
// ST_PREP and ST_DONE. Any other sample runs a PID step on one shared
// 21x25-bit signed multiplier under a small sequencer: three gain products,
// then the magnitude of the sum times mix_gain in two 20-bit halves. Input
// ready stays low from the accept until the result moves into the output
// register. A finished result sits in that output register, so the next item
// is taken while it waits. Gains are unsigned Q8.16; configuration is written
// through a plain write port (index 0..5, higher indexes are ignored); the
// user must write it only while the block is idle, which the block itself
// does not enforce.
// ----------------------------------------------------------------------------
module line_position_pd_motor_mixer
    import lpm_pkg::*;
#(
    parameter int DUTY_MAX = DUTY_MAX_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // sample channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [PAT_W-1:0]        i_sensor_pattern,
    // result channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [DUTY_W-1:0]       o_left_duty,
    output logic [DUTY_W-1:0]       o_right_duty,
    output logic [1:0]              o_action,
    output logic signed [POS_W-1:0] o_line_position,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [GAIN_W-1:0]       i_cfg_data
);

    localparam logic signed [33:0] DMAX = 34'(DUTY_MAX);

    // configuration registers
    logic [GAIN_W-1:0] r_prop_gain, r_integ_gain, r_deriv_gain, r_mix_gain;
    logic [OFS_W-1:0]  r_right_offset, r_left_offset;

    // sequencer and controller state
    t_state                   r_state, n_state;
    logic [PAT_W-1:0]         r_pat;
    logic signed [POS_W-1:0]  r_cur, n_cur;
    logic signed [POS_W-1:0]  r_prev, n_prev;
    logic signed [ISUM_W-1:0] r_isum, n_isum;
    logic signed [POS_W:0]    r_deriv, n_deriv;
    logic [DUTY_W-1:0]        r_held_l, n_held_l;
    logic [DUTY_W-1:0]        r_held_r, n_held_r;
    t_action                  r_act, n_act;

    // datapath
    logic signed [20:0] mul_a;
    logic [GAIN_W-1:0]  mul_b;
    logic signed [45:0] r_prod;
    logic signed [41:0] r_acc, n_acc;
    logic               r_neg, n_neg;
    logic [39:0]        r_mag, n_mag;
    logic [63:0]        r_s, n_s;

    // output register
    logic                    r_out_valid;
    logic [DUTY_W-1:0]       r_out_l, r_out_r;
    t_action                 r_out_act;
    logic signed [POS_W-1:0] r_out_pos;

    logic    accept;
    logic    load_out;
    t_decode dec;
    logic signed [POS_W-1:0] pos_new;
    logic signed [ISUM_W:0]  isum_sum;
    logic signed [41:0]      abs_acc;
    logic signed [33:0]      sum_plus, sum_minus;
    logic signed [33:0]      ofs_plus, ofs_minus;

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign load_out = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    assign o_valid         = r_out_valid;
    assign o_left_duty     = r_out_l;
    assign o_right_duty    = r_out_r;
    assign o_action        = r_out_act;
    assign o_line_position = r_out_pos;

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (accept) n_state = ST_PREP;
            ST_PREP:    n_state = (r_pat == '0) ? ST_DONE : ST_MUL_I;
            ST_MUL_I:   n_state = ST_MUL_D;
            ST_MUL_D:   n_state = ST_MUL_P;
            ST_MUL_P:   n_state = ST_ACC;
            ST_ACC:     n_state = ST_ABS;
            ST_ABS:     n_state = ST_MIX_LO;
            ST_MIX_LO:  n_state = ST_MIX_HI;
            ST_MIX_HI:  n_state = ST_MIX_ACC;
            ST_MIX_ACC: n_state = ST_DUTY;
            ST_DUTY:    n_state = ST_DONE;
            ST_DONE:    if (load_out) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // ----------------------------------------------------- shared multiplier feed
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_MUL_I: begin
                mul_a = 21'(r_isum);
                mul_b = r_integ_gain;
            end
            ST_MUL_D: begin
                mul_a = 21'(r_deriv);
                mul_b = r_deriv_gain;
            end
            ST_MUL_P: begin
                mul_a = 21'(r_cur);
                mul_b = r_prop_gain;
            end
            ST_MIX_LO: begin
                mul_a = {1'b0, r_mag[19:0]};
                mul_b = r_mix_gain;
            end
            ST_MIX_HI: begin
                mul_a = {1'b0, r_mag[39:20]};
                mul_b = r_mix_gain;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // decode and integral update for the PID step
    assign dec      = decode_pattern(r_pat);
    assign pos_new  = dec.hit ? dec.pos : r_cur;
    assign isum_sum = (ISUM_W + 1)'(r_isum) + (ISUM_W + 1)'(pos_new);
    assign abs_acc  = r_acc[41] ? -r_acc : r_acc;

    // duty sums: floor(ofs + t) and floor(ofs - t), t = s / 2^32
    assign ofs_plus  = 34'(r_neg ? r_left_offset : r_right_offset);
    assign ofs_minus = 34'(r_neg ? r_right_offset : r_left_offset);
    assign sum_plus  = ofs_plus + 34'(r_s[63:32]);
    assign sum_minus = ofs_minus - 34'(r_s[63:32]) - 34'(|r_s[31:0]);

    // ------------------------------------------------------------ datapath values
    always_comb begin
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_isum   = r_isum;
        n_deriv  = r_deriv;
        n_held_l = r_held_l;
        n_held_r = r_held_r;
        n_act    = r_act;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_s      = r_s;
        case (r_state)
            ST_PREP: begin
                if (r_pat == '0) begin
                    // no line: stop unless the line was lost off an edge
                    if (r_cur > -4'sd5 && r_cur < 4'sd5) begin
                        n_held_l = DMAX[DUTY_W-1:0];
                        n_held_r = DMAX[DUTY_W-1:0];
                        n_act    = ACT_STOP;
                    end else begin
                        n_act    = ACT_HOLD;
                    end
                end else begin
                    n_cur   = pos_new;
                    n_prev  = pos_new;
                    n_deriv = (POS_W + 1)'(pos_new) - (POS_W + 1)'(r_prev);
                    if (isum_sum > ISUM_LIM) begin
                        n_isum = ISUM_LIM[ISUM_W-1:0];
                    end else if (isum_sum < -ISUM_LIM) begin
                        n_isum = ISUM_W'(-ISUM_LIM);
                    end else begin
                        n_isum = isum_sum[ISUM_W-1:0];
                    end
                    n_act = ACT_DRIVE;
                end
            end
            ST_MUL_D:   n_acc = 42'(r_prod);
            ST_MUL_P:   n_acc = r_acc + 42'(r_prod);
            ST_ACC:     n_acc = r_acc + 42'(r_prod);
            ST_ABS: begin
                n_neg = r_acc[41];
                n_mag = abs_acc[39:0];
            end
            ST_MIX_HI:  n_s = 64'(r_prod[43:0]);
            ST_MIX_ACC: n_s = r_s + (64'(r_prod[43:0]) << 20);
            ST_DUTY: begin
                if (r_neg) begin
                    n_held_l = sat_duty(sum_plus, DMAX);
                    n_held_r = sat_duty(sum_minus, DMAX);
                end else begin
                    n_held_r = sat_duty(sum_plus, DMAX);
                    n_held_l = sat_duty(sum_minus, DMAX);
                end
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    // ------------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cur    <= '0;
            r_prev   <= '0;
            r_isum   <= '0;
            r_held_l <= '0;
            r_held_r <= '0;
            r_act    <= ACT_DRIVE;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_prev   <= n_prev;
            r_isum   <= n_isum;
            r_held_l <= n_held_l;
            r_held_r <= n_held_r;
            r_act    <= n_act;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pat <= i_sensor_pattern;
        end
        r_deriv <= n_deriv;
        r_acc   <= n_acc;
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_s     <= n_s;
        r_prod  <= mul_a * $signed({1'b0, mul_b});
    end

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain    <= RST_PROP_GAIN;
            r_integ_gain   <= RST_INTEG_GAIN;
            r_deriv_gain   <= RST_DERIV_GAIN;
            r_mix_gain     <= RST_MIX_GAIN;
            r_right_offset <= RST_RIGHT_OFFSET;
            r_left_offset  <= RST_LEFT_OFFSET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PROP_GAIN:    r_prop_gain    <= i_cfg_data;
                REG_INTEG_GAIN:   r_integ_gain   <= i_cfg_data;
                REG_DERIV_GAIN:   r_deriv_gain   <= i_cfg_data;
                REG_MIX_GAIN:     r_mix_gain     <= i_cfg_data;
                REG_RIGHT_OFFSET: r_right_offset <= i_cfg_data[OFS_W-1:0];
                REG_LEFT_OFFSET:  r_left_offset  <= i_cfg_data[OFS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // output register: load a finished item, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_l   <= r_held_l;
            r_out_r   <= r_held_r;
            r_out_act <= r_act;
            r_out_pos <= r_cur;
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the line position PID motor mixer
// Streams six-bit sensor samples through the valid/ready sample channel and
// checks every result item (duties, action, line position) against a
// cycle-free model of the decode, PID and mixing arithmetic kept in the bench.
// Runs directed corner cases, randomized phases under changing gains and
// offsets, a long output stall and an integral windup run.
// ----------------------------------------------------------------------------
module tb;
    import lpm_pkg::*;

    localparam int DUTY_LIM = DUTY_MAX_DEF;

    // Indexes past the register file; writes to them must have no effect.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam logic [GAIN_W-1:0] GAIN_MAX = 24'hFFFFFF;
    localparam int ISUM_MAX = 32767;

    // Receiver stall styles.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    // One expected result item.
    typedef struct {
        logic [DUTY_W-1:0]       left;
        logic [DUTY_W-1:0]       right;
        t_action                 act;
        logic signed [POS_W-1:0] pos;
    } t_motor_cmd;

    logic                    i_clk;
    logic                    i_rst_n          = 1'b0;
    logic                    i_valid          = 1'b0;
    logic                    o_ready;
    logic [PAT_W-1:0]        i_sensor_pattern = '0;
    logic                    o_valid;
    logic                    i_ready          = 1'b0;
    logic [DUTY_W-1:0]       o_left_duty;
    logic [DUTY_W-1:0]       o_right_duty;
    logic [1:0]              o_action;
    logic signed [POS_W-1:0] o_line_position;
    logic                    i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx        = '0;
    logic [GAIN_W-1:0]       i_cfg_data       = '0;

    line_position_pd_motor_mixer #(
        .DUTY_MAX(DUTY_LIM)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sensor_pattern(i_sensor_pattern),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_left_duty     (o_left_duty),
        .o_right_duty    (o_right_duty),
        .o_action        (o_action),
        .o_line_position (o_line_position),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench copy of the block's registers and control state
    // ------------------------------------------------------------------------
    logic [GAIN_W-1:0] kp       = RST_PROP_GAIN;
    logic [GAIN_W-1:0] ki       = RST_INTEG_GAIN;
    logic [GAIN_W-1:0] kd       = RST_DERIV_GAIN;
    logic [GAIN_W-1:0] kmix     = RST_MIX_GAIN;
    logic [OFS_W-1:0]  ofs_right = RST_RIGHT_OFFSET;
    logic [OFS_W-1:0]  ofs_left  = RST_LEFT_OFFSET;

    int                trk_pos  = 0;
    int                trk_prev = 0;
    int                trk_isum = 0;
    logic [DUTY_W-1:0] held_left_q  = '0;
    logic [DUTY_W-1:0] held_right_q = '0;

    t_motor_cmd pending_cmds[$];
    int         err_cnt = 0;

    t_rx_mode    rx_mode = RX_OPEN;
    logic        rx_hold = 1'b0;
    logic [15:0] rx_pat  = 16'hFFFF;

    // Clamp an exact duty sum into the motor range.
    function automatic logic [DUTY_W-1:0] clamp_duty(input longint v);
        if (v < 0) begin
            return '0;
        end else if (v > DUTY_LIM) begin
            return DUTY_W'(DUTY_LIM);
        end
        return v[DUTY_W-1:0];
    endfunction

    // Advance the bench state by one sample and return the result it causes.
    function automatic t_motor_cmd next_motor_cmd(input logic [PAT_W-1:0] pat);
        t_motor_cmd c;
        longint     pd;
        longint     ip;
        longint     fix;
        bit [63:0]  mag;
        bit [63:0]  prod;
        int         isum_n;
        int         dv;
        bit         neg;

        if (pat == '0) begin
            // No line seen: stop unless the line was lost off an edge.
            if (trk_pos > -5 && trk_pos < 5) begin
                held_left_q  = DUTY_W'(DUTY_LIM);
                held_right_q = DUTY_W'(DUTY_LIM);
                c.act = ACT_STOP;
            end else begin
                c.act = ACT_HOLD;
            end
        end else begin
            // Decode one sensor or two adjacent sensors; keep position otherwise.
            case (pat)
                6'h01: trk_pos = 5;
                6'h03: trk_pos = 4;
                6'h02: trk_pos = 3;
                6'h06: trk_pos = 2;
                6'h04: trk_pos = 1;
                6'h0C: trk_pos = 0;
                6'h08: trk_pos = -1;
                6'h18: trk_pos = -2;
                6'h10: trk_pos = -3;
                6'h30: trk_pos = -4;
                6'h20: trk_pos = -5;
                default: ;
            endcase

            isum_n = trk_isum + trk_pos;
            if (isum_n > ISUM_MAX) isum_n = ISUM_MAX;
            if (isum_n < -ISUM_MAX) isum_n = -ISUM_MAX;
            trk_isum = isum_n;

            dv = trk_pos - trk_prev;
            trk_prev = trk_pos;

            pd = longint'(trk_isum) * longint'(ki) + longint'(dv) * longint'(kd)
               + longint'(trk_pos) * longint'(kp);

            // Scale the magnitude, then floor toward minus infinity per side.
            neg  = (pd < 0);
            mag  = neg ? 64'(-pd) : 64'(pd);
            prod = mag * {40'd0, kmix};
            ip   = longint'(prod >> 32);
            fix  = (prod[31:0] != 32'd0) ? 1 : 0;
            if (!neg) begin
                held_right_q = clamp_duty(longint'(ofs_right) + ip);
                held_left_q  = clamp_duty(longint'(ofs_left) - ip - fix);
            end else begin
                held_right_q = clamp_duty(longint'(ofs_right) - ip - fix);
                held_left_q  = clamp_duty(longint'(ofs_left) + ip);
            end
            c.act = ACT_DRIVE;
        end

        c.left  = held_left_q;
        c.right = held_right_q;
        c.pos   = POS_W'(trk_pos);
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, receiver and result checker
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drive output ready on the falling edge; a hold-off overrides the style.
    always @(negedge i_clk) begin
        rx_pat = {rx_pat[0], rx_pat[15:1]};
        if (rx_hold) begin
            i_ready = 1'b0;
        end else begin
            case (rx_mode)
                RX_RANDOM:  i_ready = ($urandom_range(99) >= 35);
                RX_PATTERN: i_ready = rx_pat[0];
                default:    i_ready = 1'b1;
            endcase
        end
    end

    // Compare each accepted result item with the oldest expectation.
    always @(posedge i_clk) begin
        t_motor_cmd e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected result item left=%0d right=%0d action=%0d pos=%0d",
                         $time, o_left_duty, o_right_duty, o_action, o_line_position);
                err_cnt++;
            end else begin
                e = pending_cmds.pop_front();
                if (o_left_duty !== e.left) begin
                    $display("%0t: left_duty expected %0d got %0d",
                             $time, e.left, o_left_duty);
                    err_cnt++;
                end
                if (o_right_duty !== e.right) begin
                    $display("%0t: right_duty expected %0d got %0d",
                             $time, e.right, o_right_duty);
                    err_cnt++;
                end
                if (o_action !== e.act) begin
                    $display("%0t: action expected %0d got %0d",
                             $time, e.act, o_action);
                    err_cnt++;
                end
                if (o_line_position !== e.pos) begin
                    $display("%0t: line_position expected %0d got %0d",
                             $time, e.pos, o_line_position);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared driver tasks
    // ------------------------------------------------------------------------

    // Offer one sample; leave valid high so a following item goes back to back.
    task automatic send_item(input logic [PAT_W-1:0] pat);
        @(negedge i_clk);
        i_valid = 1'b1;
        i_sensor_pattern = pat;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_cmds.push_back(next_motor_cmd(pat));
    endtask

    // Drop valid and let the sender idle.
    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
    endtask

    // Drain every outstanding result, then let the sequencer fall idle.
    task automatic settle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // Write one register and mirror it with the block's field widths.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [GAIN_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_PROP_GAIN:    kp        = data;
            REG_INTEG_GAIN:   ki        = data;
            REG_DERIV_GAIN:   kd        = data;
            REG_MIX_GAIN:     kmix      = data;
            REG_RIGHT_OFFSET: ofs_right = data[OFS_W-1:0];
            REG_LEFT_OFFSET:  ofs_left  = data[OFS_W-1:0];
            default: ;
        endcase
    endtask

    // Gain spread over zero, full scale, any value and small useful values.
    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(4))
            0: return '0;
            1: return GAIN_MAX;
            2: return GAIN_W'($urandom_range(0, 24'hFFFFFF));
            3: return GAIN_W'($urandom_range(0, 1 << 17));
            default: return GAIN_W'($urandom_range(0, 1 << 12));
        endcase
    endfunction

    // Mostly decodable samples, some line losses, the rest arbitrary.
    function automatic logic [PAT_W-1:0] rand_pattern();
        logic [PAT_W-1:0] listed[11] = '{6'h01, 6'h03, 6'h02, 6'h06, 6'h04, 6'h0C,
                                         6'h08, 6'h18, 6'h10, 6'h30, 6'h20};
        int r;
        r = $urandom_range(99);
        if (r < 55) return listed[$urandom_range(10)];
        if (r < 70) return '0;
        return PAT_W'($urandom_range(1, 63));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Walk every decode entry at reset gains, with stop, hold and unlisted cases.
    task automatic test_decode_and_line_loss();
        logic [PAT_W-1:0] seq[16] = '{6'h01, 6'h00, 6'h20, 6'h00, 6'h0C, 6'h00,
                                      6'h3F, 6'h15, 6'h03, 6'h02, 6'h06, 6'h04,
                                      6'h08, 6'h18, 6'h10, 6'h30};
        foreach (seq[i]) send_item(seq[i]);
        // Lose the line at -4: still inside the stop window.
        send_item(6'h00);
        send_item(6'h2A);
    endtask

    // Push every register to both extremes; spare indexes must be ignored.
    task automatic test_register_extremes();
        settle();
        write_reg(REG_PROP_GAIN,    GAIN_MAX);
        write_reg(REG_INTEG_GAIN,   GAIN_MAX);
        write_reg(REG_DERIV_GAIN,   GAIN_MAX);
        write_reg(REG_MIX_GAIN,     GAIN_MAX);
        write_reg(REG_RIGHT_OFFSET, GAIN_MAX);   // upper bits dropped
        write_reg(REG_LEFT_OFFSET,  GAIN_MAX);
        send_item(6'h20);
        send_item(6'h01);
        send_item(6'h21);
        settle();
        write_reg(REG_PROP_GAIN,    '0);
        write_reg(REG_INTEG_GAIN,   '0);
        write_reg(REG_DERIV_GAIN,   '0);
        write_reg(REG_MIX_GAIN,     '0);
        write_reg(REG_RIGHT_OFFSET, 24'hFFFC00);
        write_reg(REG_LEFT_OFFSET,  '0);
        write_reg(REG_SPARE_6,      GAIN_MAX);
        write_reg(REG_SPARE_7,      24'h5A5A5A);
        send_item(6'h04);
        send_item(6'h30);
        send_item(6'h00);
    endtask

    // Randomized phases, each under new registers and a new idling style.
    task automatic test_random_phases();
        int burst;
        for (int ph = 0; ph < 10; ph++) begin
            settle();
            write_reg(REG_PROP_GAIN,  rand_gain());
            write_reg(REG_INTEG_GAIN, rand_gain());
            write_reg(REG_DERIV_GAIN, rand_gain());
            write_reg(REG_MIX_GAIN,   rand_gain());
            write_reg(REG_RIGHT_OFFSET, GAIN_W'($urandom));
            write_reg(REG_LEFT_OFFSET,  GAIN_W'($urandom));
            if ($urandom_range(1)) begin
                write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, GAIN_W'($urandom));
            end
            rx_mode = t_rx_mode'(ph % 3);
            rx_pat  = 16'($urandom) | 16'h0001;   // keep at least one ready slot
            burst   = $urandom_range(1, 16);
            for (int n = 0; n < 150; n++) begin
                send_item(rand_pattern());
                // Every fourth phase streams without sender gaps.
                if (ph % 4 != 3) begin
                    burst--;
                    if (burst == 0) begin
                        idle_cycles($urandom_range(1, 10));
                        burst = $urandom_range(1, 16);
                    end
                end
            end
        end
    endtask

    // Hold the receiver off long enough that the block backs up its input.
    task automatic test_output_stall();
        settle();
        rx_mode = RX_OPEN;
        fork
            begin
                rx_hold = 1'b1;
                repeat (300) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            begin
                repeat (24) send_item(rand_pattern());
            end
        join
    endtask

    // Wind the integral up on one side, then swing the line to the other side.
    task automatic test_integral_windup();
        settle();
        rx_mode = RX_OPEN;
        // Integral term alone, about isum/256 duty steps: the windup shows in the floor.
        write_reg(REG_PROP_GAIN,    '0);
        write_reg(REG_DERIV_GAIN,   '0);
        write_reg(REG_INTEG_GAIN,   24'd256);
        write_reg(REG_MIX_GAIN,     24'd65536);
        write_reg(REG_RIGHT_OFFSET, 24'd300);
        write_reg(REG_LEFT_OFFSET,  24'd700);
        repeat (120) send_item(6'h01);
        repeat (6) send_item(6'h20);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_decode_and_line_loss();
        test_register_extremes();
        test_random_phases();
        test_output_stall();
        test_integral_windup();

        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Bound the run far beyond the slowest correct schedule.
    initial begin
        #10ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
src/lpm_pkg.sv
src/line_position_pd_motor_mixer.sv
tb/tb.sv
